FILE: rtl/core/i2c_write_master_assert.svh
// Assertion macros for the i2c write master RTL, used by the back part
`ifndef I2C_WRITE_MASTER_ASSERT_SVH
`define I2C_WRITE_MASTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2CWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2c write master: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define I2CWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2c write master: next-cycle check failed");

`endif

FILE: rtl/core/i2cwm_pkg.sv
// Package: types, codes and line tables for the i2c write master
package i2cwm_pkg;

	// Command codes on the operation field
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Line drive bits: bit 1 SDA released, bit 0 SCL released
	localparam logic [1:0] LINES_IDLE = 2'b11;
	localparam int SCL_IDX = 0;
	localparam int SDA_IDX = 1;

	// Phase positions inside one bit or one condition
	localparam logic [1:0] SUB_FIRST = 2'd0;
	localparam logic [1:0] SUB_DATA  = 2'd1;
	localparam logic [1:0] SUB_LAST  = 2'd2;
	localparam logic [3:0] BIT_LAST  = 4'd8;

	typedef enum logic [1:0] {
		KIND_IDLE  = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_WRITE = 2'd3
	} kind_t;

	// One classified tick as it travels from front to back
	typedef struct packed {
		logic       cmd_ok;
		kind_t      kind;
		logic [8:0] shift;
		logic       sda_in;
	} tick_item_t;

	// One result item
	typedef struct packed {
		logic scl_release;
		logic sda_release;
		logic ready_res;
		logic ack_valid;
		logic acked;
	} res_t;

	// Queue handshake toward the back part
	typedef struct packed {
		logic       valid;
		tick_item_t item;
	} queue_out_t;

	// Lines of a start or stop condition at a given phase
	function automatic logic [1:0] cond_lines(input kind_t kind, input logic [1:0] sub);
		logic [1:0] lines;
		lines = LINES_IDLE;
		case (sub)
			SUB_FIRST: lines = (kind == KIND_START) ? 2'b11 : 2'b00;
			SUB_DATA:  lines = 2'b01;
			SUB_LAST:  lines = (kind == KIND_START) ? 2'b00 : 2'b11;
			default:   lines = LINES_IDLE;
		endcase
		return lines;
	endfunction

endpackage

FILE: rtl/core/i2cwm_if.sv
// Channel interfaces: tick items in, line result items out

interface i2cwm_tick_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] operation;
	logic [7:0] write_byte;
	logic       sda_in;

	modport source (output valid, output cmd_valid, output operation,
		output write_byte, output sda_in, input ready);
	modport sink (input valid, input cmd_valid, input operation,
		input write_byte, input sda_in, output ready);
endinterface

interface i2cwm_res_if;
	logic valid;
	logic ready;
	logic scl_release;
	logic sda_release;
	logic ready_res;
	logic ack_valid;
	logic acked;

	modport source (output valid, output scl_release, output sda_release,
		output ready_res, output ack_valid, output acked, input ready);
	modport sink (input valid, input scl_release, input sda_release,
		input ready_res, input ack_valid, input acked, output ready);
endinterface

FILE: rtl/core/i2c_write_master.sv
// Top level of the open-drain i2c write master
//
//   channel   | dir | handshake       | payload
//   ----------+-----+-----------------+---------------------------------------------
//   tick      | in  | valid / ready   | cmd_valid, operation, write_byte, sda_in
//   res       | out | valid / ready   | scl_release, sda_release, ready_res, ack_valid, acked
//   cfg       | in  | cfg_we          | cfg_wdata = phase_ticks
//
// One result item per tick item; a tick is taken every cycle when res is not stalled.
// A tick passes through the queue and then the output register before its result appears.
// The sequencer in the back part updates once per tick item that it pops.
// A stalled res output fills the queue; tick ready drops only once the queue is full.
// Reset (arst_n low) releases both lines, empties the queue and sets phase_ticks to 1.
module i2c_write_master #(
	parameter int QUEUE_DEPTH = i2cwm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	i2cwm_tick_if.sink  tick,
	i2cwm_res_if.source res
);

	logic                  push;
	logic                  pop;
	logic                  queue_full;
	i2cwm_pkg::tick_item_t push_item;
	i2cwm_pkg::queue_out_t head;

	i2cwm_front u_front (
		.tick       (tick),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	i2cwm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (queue_full),
		.head      (head)
	);

	i2cwm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.res       (res)
	);

endmodule

FILE: rtl/core/i2cwm_front.sv
// Front part: takes tick items and classifies their command
module i2cwm_front (
	i2cwm_tick_if.sink          tick,
	input  logic                queue_full,
	output logic                push,
	output i2cwm_pkg::tick_item_t push_item
);

	// Accept whenever the queue has room
	assign tick.ready = !queue_full;
	assign push       = tick.valid && !queue_full;

	// Decode the command and build the nine-bit shift word
	always_comb begin
		push_item        = '0;
		push_item.sda_in = tick.sda_in;
		push_item.shift  = {tick.write_byte, 1'b1};
		push_item.kind   = i2cwm_pkg::KIND_IDLE;
		push_item.cmd_ok = 1'b0;
		if (tick.cmd_valid) begin
			case (tick.operation)
				i2cwm_pkg::OP_START: begin
					push_item.kind   = i2cwm_pkg::KIND_START;
					push_item.cmd_ok = 1'b1;
				end
				i2cwm_pkg::OP_STOP: begin
					push_item.kind   = i2cwm_pkg::KIND_STOP;
					push_item.cmd_ok = 1'b1;
				end
				i2cwm_pkg::OP_WRITE: begin
					push_item.kind   = i2cwm_pkg::KIND_WRITE;
					push_item.cmd_ok = 1'b1;
				end
				default: push_item.cmd_ok = 1'b0;
			endcase
		end
	end

endmodule

FILE: rtl/core/i2cwm_queue.sv
// Short FIFO of classified tick items between front and back
module i2cwm_queue #(
	parameter int DEPTH = i2cwm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  i2cwm_pkg::tick_item_t push_item,
	input  logic                  pop,
	output logic                  full,
	output i2cwm_pkg::queue_out_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	i2cwm_pkg::tick_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/i2cwm_back.sv
// Back part: bus line sequencer and result output register
`include "i2c_write_master_assert.svh"

module i2cwm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  i2cwm_pkg::queue_out_t head,
	output logic                  pop,
	i2cwm_res_if.source           res
);

	i2cwm_pkg::kind_t kind_q, kind_d;
	logic [1:0] lines_q, lines_d;
	logic [1:0] sub_q, sub_d;
	logic [3:0] bit_q, bit_d;
	logic [8:0] shift_q, shift_d;
	logic [7:0] tick_q, tick_d;
	logic [7:0] phase_ticks_q;
	logic [7:0] len;
	logic       phase_end;
	logic       done;
	logic       out_valid_q;
	i2cwm_pkg::res_t res_q, res_d;

	// Take the next tick when the output register is free or draining
	assign pop = head.valid && (!out_valid_q || res.ready);

	assign len       = (phase_ticks_q == '0) ? 8'd1 : phase_ticks_q;
	assign phase_end = ({1'b0, tick_q} + 9'd1) >= {1'b0, len};

	// Next state of the sequencer for one tick
	always_comb begin
		kind_d  = kind_q;
		lines_d = lines_q;
		sub_d   = sub_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		tick_d  = tick_q;
		done    = 1'b0;
		if (kind_q == i2cwm_pkg::KIND_IDLE) begin
			if (head.item.cmd_ok) begin
				kind_d = head.item.kind;
				sub_d  = i2cwm_pkg::SUB_FIRST;
				bit_d  = '0;
				tick_d = '0;
				if (head.item.kind == i2cwm_pkg::KIND_WRITE) begin
					shift_d = head.item.shift;
					lines_d[i2cwm_pkg::SCL_IDX] = 1'b0;
				end else begin
					lines_d = i2cwm_pkg::cond_lines(head.item.kind, i2cwm_pkg::SUB_FIRST);
				end
			end
		end else if (phase_end) begin
			tick_d = '0;
			if (sub_q == i2cwm_pkg::SUB_LAST &&
				(kind_q != i2cwm_pkg::KIND_WRITE || bit_q == i2cwm_pkg::BIT_LAST)) begin
				// Sequence finished; a write samples the ack and pulls SCL low
				if (kind_q == i2cwm_pkg::KIND_WRITE) begin
					done = 1'b1;
					lines_d[i2cwm_pkg::SCL_IDX] = 1'b0;
				end
				kind_d = i2cwm_pkg::KIND_IDLE;
				sub_d  = i2cwm_pkg::SUB_FIRST;
				bit_d  = '0;
			end else if (kind_q == i2cwm_pkg::KIND_WRITE) begin
				case (sub_q)
					i2cwm_pkg::SUB_FIRST: begin
						sub_d   = i2cwm_pkg::SUB_DATA;
						lines_d = {shift_q[8], 1'b0};
						shift_d = {shift_q[7:0], 1'b0};
					end
					i2cwm_pkg::SUB_DATA: begin
						sub_d = i2cwm_pkg::SUB_LAST;
						lines_d[i2cwm_pkg::SCL_IDX] = 1'b1;
					end
					default: begin
						sub_d = i2cwm_pkg::SUB_FIRST;
						bit_d = bit_q + 4'd1;
						lines_d[i2cwm_pkg::SCL_IDX] = 1'b0;
					end
				endcase
			end else begin
				sub_d   = sub_q + 2'd1;
				lines_d = i2cwm_pkg::cond_lines(kind_q, sub_q + 2'd1);
			end
		end else begin
			tick_d = tick_q + 8'd1;
		end
	end

	// Result fields for this tick
	always_comb begin
		res_d.scl_release = lines_d[i2cwm_pkg::SCL_IDX];
		res_d.sda_release = lines_d[i2cwm_pkg::SDA_IDX];
		res_d.ready_res   = (kind_d == i2cwm_pkg::KIND_IDLE);
		res_d.ack_valid   = done;
		res_d.acked       = done && !head.item.sda_in;
	end

	// Sequencer state and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q        <= i2cwm_pkg::KIND_IDLE;
			lines_q       <= i2cwm_pkg::LINES_IDLE;
			sub_q         <= i2cwm_pkg::SUB_FIRST;
			bit_q         <= '0;
			shift_q       <= '0;
			tick_q        <= '0;
			phase_ticks_q <= 8'd1;
		end else begin
			if (cfg_we) begin
				phase_ticks_q <= cfg_wdata;
			end
			if (pop) begin
				kind_q  <= kind_d;
				lines_q <= lines_d;
				sub_q   <= sub_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				tick_q  <= tick_d;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.scl_release = res_q.scl_release;
	assign res.sda_release = res_q.sda_release;
	assign res.ready_res   = res_q.ready_res;
	assign res.ack_valid   = res_q.ack_valid;
	assign res.acked       = res_q.acked;

	// A completed write always returns the master to idle with SCL low
	`I2CWM_ASSERT_NOW(a_done_idle, clk, arst_n, done,
		res_d.ready_res && !res_d.scl_release)
	// An ignored tick while idle leaves the master idle
	`I2CWM_ASSERT_NEXT(a_ignored_stays_idle, clk, arst_n,
		pop && kind_q == i2cwm_pkg::KIND_IDLE && !head.item.cmd_ok,
		kind_q == i2cwm_pkg::KIND_IDLE)
	// Bit counter never runs past the ninth bit
	`I2CWM_ASSERT_NOW(a_bit_range, clk, arst_n, kind_q == i2cwm_pkg::KIND_WRITE,
		bit_q <= i2cwm_pkg::BIT_LAST && sub_q <= i2cwm_pkg::SUB_LAST)
	// A stalled result stays valid in the register until it is taken
	`I2CWM_ASSERT_NEXT(a_stall_keeps_valid, clk, arst_n, out_valid_q && !res.ready,
		out_valid_q)

endmodule

FILE: verif/tb_i2c_write_master.sv
// Testbench for i2c_write_master: directed and random tick items checked against a line-sequence predictor
module tb_i2c_write_master;

	// Operation code the master must ignore
	localparam logic [1:0] OP_NONE = 2'd3;

	// Phases per write byte (nine bits of three) and per start or stop
	localparam int WRITE_PHASES = 27;
	localparam int COND_PHASES  = 3;

	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int PHASE_ITEMS = 110;
	localparam int DEEP_TAIL   = 400;
	localparam int N_PHASES    = 9;
	localparam int PTK_PLAN[N_PHASES] = '{2, 0, 3, 1, 255, 2, 5, 1, 4};

	typedef enum {SDA_LOW, SDA_HIGH, SDA_COIN} sda_mode_t;

	// Predicts the bus lines per tick and keeps the line results still due
	class bus_line_tracker;
		logic [7:0]       ptk;
		logic [1:0]       lines;
		i2cwm_pkg::kind_t kind;
		logic [5:0]       phase;
		logic [8:0]       shifter;
		logic [7:0]       held;
		logic             ack_bit;
		i2cwm_pkg::res_t  lines_due[$];
		int               mismatches;

		function new();
			ptk = 8'd1;
			lines = i2cwm_pkg::LINES_IDLE;
			kind = i2cwm_pkg::KIND_IDLE;
			phase = '0;
			shifter = '0;
			held = '0;
			ack_bit = 1'b0;
			mismatches = 0;
		endfunction

		function void set_phase_ticks(logic [7:0] v);
			ptk = v;
		endfunction

		function bit master_idle();
			return kind == i2cwm_pkg::KIND_IDLE;
		endfunction

		function int waiting();
			return lines_due.size();
		endfunction

		// Lines for the phase that just began
		function void drive_phase();
			logic [1:0] sub;
			int bit_no;
			sub = 2'(phase % 3);
			bit_no = (phase / 3) % 9;
			case (kind)
				i2cwm_pkg::KIND_START: begin
					case (sub)
						i2cwm_pkg::SUB_FIRST: lines = 2'b11;
						i2cwm_pkg::SUB_DATA:  lines = 2'b01;
						default:              lines = 2'b00;
					endcase
				end
				i2cwm_pkg::KIND_STOP: begin
					case (sub)
						i2cwm_pkg::SUB_FIRST: lines = 2'b00;
						i2cwm_pkg::SUB_DATA:  lines = 2'b01;
						default:              lines = 2'b11;
					endcase
				end
				i2cwm_pkg::KIND_WRITE: begin
					case (sub)
						i2cwm_pkg::SUB_FIRST: lines[i2cwm_pkg::SCL_IDX] = 1'b0;
						i2cwm_pkg::SUB_DATA:  lines = {shifter[8 - bit_no], 1'b0};
						default:              lines[i2cwm_pkg::SCL_IDX] = 1'b1;
					endcase
				end
				default: ;
			endcase
		endfunction

		// One accepted tick: advance the sequencer, queue the line result
		function void tick_taken(logic cv, logic [1:0] op, logic [7:0] wb, logic sda);
			int len;
			int last;
			i2cwm_pkg::res_t want;
			want = '0;
			len = (ptk == 8'd0) ? 1 : int'(ptk);
			if (kind == i2cwm_pkg::KIND_IDLE) begin
				if (cv) begin
					case (op)
						i2cwm_pkg::OP_START: kind = i2cwm_pkg::KIND_START;
						i2cwm_pkg::OP_STOP:  kind = i2cwm_pkg::KIND_STOP;
						i2cwm_pkg::OP_WRITE: begin
							kind = i2cwm_pkg::KIND_WRITE;
							shifter = {wb, 1'b1};
						end
						default: ;
					endcase
					if (kind != i2cwm_pkg::KIND_IDLE) begin
						phase = '0;
						held = '0;
						drive_phase();
					end
				end
			end else if (int'(held) + 1 >= len) begin
				last = (kind == i2cwm_pkg::KIND_WRITE) ? WRITE_PHASES : COND_PHASES;
				held = '0;
				if (int'(phase) + 1 >= last) begin
					// sequence done; for a write (ninth bit done) ack is SDA low, SCL pulled low
					if (kind == i2cwm_pkg::KIND_WRITE) begin
						ack_bit = !sda;
						lines[i2cwm_pkg::SCL_IDX] = 1'b0;
						want.ack_valid = 1'b1;
						want.acked = ack_bit;
					end
					kind = i2cwm_pkg::KIND_IDLE;
					phase = '0;
				end else begin
					phase = phase + 6'd1;
					drive_phase();
				end
			end else begin
				held = held + 8'd1;
			end
			want.scl_release = lines[i2cwm_pkg::SCL_IDX];
			want.sda_release = lines[i2cwm_pkg::SDA_IDX];
			want.ready_res = (kind == i2cwm_pkg::KIND_IDLE);
			lines_due.push_back(want);
		endfunction

		function void complain(string what, i2cwm_pkg::res_t want, i2cwm_pkg::res_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$write("%0t: %s: want scl=%b sda=%b rdy=%b ackv=%b ack=%b, ",
					$time, what, want.scl_release, want.sda_release, want.ready_res,
					want.ack_valid, want.acked);
				$display("got scl=%b sda=%b rdy=%b ackv=%b ack=%b",
					got.scl_release, got.sda_release, got.ready_res,
					got.ack_valid, got.acked);
			end
		endfunction

		// One accepted result item against the oldest prediction
		function void line_result(i2cwm_pkg::res_t got);
			i2cwm_pkg::res_t want;
			if (lines_due.size() == 0) begin
				complain("result with nothing expected", '0, got);
				return;
			end
			want = lines_due.pop_front();
			if (want.scl_release !== got.scl_release || want.sda_release !== got.sda_release ||
					want.ready_res !== got.ready_res || want.ack_valid !== got.ack_valid ||
					want.acked !== got.acked)
				complain("line result differs", want, got);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	bit         steady;
	bit         long_hold_req;

	i2cwm_tick_if tick_ch();
	i2cwm_res_if  res_ch();

	bus_line_tracker sb = new();

	i2c_write_master uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.res       (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none, some short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic pick_sda(sda_mode_t mode);
		case (mode)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			default:  return 1'($urandom);
		endcase
	endfunction

	// Offer one tick item and hold it until accepted; returns on a falling edge
	task automatic send_tick(logic cv, logic [1:0] op, logic [7:0] wb, logic sda);
		int g;
		g = steady ? 0 : gap_len();
		if (g > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.cmd_valid <= cv;
		tick_ch.operation <= op;
		tick_ch.write_byte <= wb;
		tick_ch.sda_in <= sda;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Issue a command while idle, then fill with busy noise until the master is free
	task automatic run_cmd(logic [1:0] op, logic [7:0] wb, sda_mode_t mode);
		send_tick(1'b1, op, wb, pick_sda(mode));
		while (!sb.master_idle())
			send_tick(1'($urandom), 2'($urandom), 8'($urandom), pick_sda(mode));
	endtask

	// Mostly well-formed commands when idle, noise while busy
	task automatic random_tick();
		int r;
		logic [1:0] op;
		r = $urandom_range(0, 19);
		if (sb.master_idle() && r < 17) begin
			op = (r < 9) ? i2cwm_pkg::OP_WRITE : (r < 12) ? i2cwm_pkg::OP_START :
				(r < 15) ? i2cwm_pkg::OP_STOP : (r == 15) ? OP_NONE : i2cwm_pkg::OP_WRITE;
			send_tick(r != 16, op, 8'($urandom), 1'($urandom));
		end else begin
			send_tick(1'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
		end
	endtask

	// Stop offering and wait for every predicted result
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (sb.waiting() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_phase_ticks(logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_phase_ticks(v);
	endtask

	// Result side: random stalls, one long hold on request
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
				res_ch.ready <= 1'b0;
			end else if (steady || $urandom_range(0, 3) != 0) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b0;
				stall_left = gap_len();
			end
		end
	end

	// Handshake monitor feeding the predictor and the checker
	always @(posedge clk) begin : monitor
		i2cwm_pkg::res_t got;
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready)
				sb.tick_taken(tick_ch.cmd_valid, tick_ch.operation, tick_ch.write_byte,
					tick_ch.sda_in);
			if (res_ch.valid && res_ch.ready) begin
				got.scl_release = res_ch.scl_release;
				got.sda_release = res_ch.sda_release;
				got.ready_res = res_ch.ready_res;
				got.ack_valid = res_ch.ack_valid;
				got.acked = res_ch.acked;
				sb.line_result(got);
			end
		end
	end

	// Watchdog: too long without any item moving
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		steady = 1'b0;
		long_hold_req = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'd0;
		tick_ch.valid <= 1'b0;
		tick_ch.cmd_valid <= 1'b0;
		tick_ch.operation <= i2cwm_pkg::OP_START;
		tick_ch.write_byte <= 8'd0;
		tick_ch.sda_in <= 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: no command, unknown op, every command, ack and nack, busy noise
		send_tick(1'b0, i2cwm_pkg::OP_WRITE, 8'hFF, 1'b1);
		send_tick(1'b1, OP_NONE, 8'h5A, 1'b0);
		run_cmd(i2cwm_pkg::OP_START, 8'h00, SDA_COIN);
		run_cmd(i2cwm_pkg::OP_WRITE, 8'h00, SDA_LOW);
		run_cmd(i2cwm_pkg::OP_WRITE, 8'hFF, SDA_HIGH);
		run_cmd(i2cwm_pkg::OP_WRITE, 8'hA5, SDA_COIN);
		run_cmd(i2cwm_pkg::OP_WRITE, 8'h80, SDA_LOW);
		run_cmd(i2cwm_pkg::OP_WRITE, 8'h01, SDA_HIGH);
		run_cmd(i2cwm_pkg::OP_STOP, 8'h00, SDA_COIN);

		// Random phases over several phase lengths; config changes may land mid-sequence
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			write_phase_ticks(8'(PTK_PLAN[p]));
			steady = (p == 5);
			if (p == 2)
				long_hold_req = 1'b1;
			if (PTK_PLAN[p] == 255) begin
				// longest phases: a write cut short past its first full phase
				send_tick(1'b1, i2cwm_pkg::OP_WRITE, 8'($urandom), 1'($urandom));
				repeat (DEEP_TAIL) random_tick();
			end else begin
				repeat (PHASE_ITEMS) random_tick();
			end
		end
		steady = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.waiting() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: i2c_write_master.f
+incdir+rtl/core
rtl/core/i2cwm_pkg.sv
rtl/core/i2cwm_if.sv
rtl/core/i2cwm_front.sv
rtl/core/i2cwm_queue.sv
rtl/core/i2cwm_back.sv
rtl/core/i2c_write_master.sv
verif/tb_i2c_write_master.sv
